@@ hdl/sarc_pkg.sv @@
// ============================================================================
// sarc_pkg: shared types and constants of the stereo audio rate converter
// Frame payloads, the request to the shared arithmetic unit and its op codes.
// ============================================================================
package sarc_pkg;

    localparam int RATE_W              = 21;
    localparam int SAMPLE_W            = 16;
    localparam int PHASE_W             = 22;
    localparam int SUM_W               = 18;
    localparam int DEFAULT_OUTPUT_RATE = 65536;

    localparam logic [RATE_W-1:0]  RESET_RATE = RATE_W'(65536);
    localparam logic [RATE_W-1:0]  MIN_STEP   = RATE_W'(8192);
    localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(32'h0001_0000);

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t left_in;
        sample_t right_in;
    } in_frame_t;

    typedef struct packed {
        sample_t left_out;
        sample_t right_out;
        logic    last_of_run;
    } out_frame_t;

    typedef enum logic [2:0] {
        ALU_PASS,
        ALU_HALF,
        ALU_AVG2,
        ALU_AVG4,
        ALU_LERP
    } alu_op_t;

    typedef struct packed {
        alu_op_t                  op;
        logic signed [SUM_W-1:0]  opa;
        sample_t                  opb;
        logic [15:0]              frac;
    } alu_req_t;

endpackage

@@ hdl/sarc_stream_if.sv @@
// ============================================================================
// sarc_stream_if: valid/ready channel carrying one frame per item
// The payload type is chosen where the channel is instantiated.
// ============================================================================
interface sarc_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

@@ hdl/stereo_audio_rate_converter_top.sv @@
// Each result of an accepted item passes the issue-left, issue-right, capture
// and emit states, using the two-stage shared unit once per channel. An item
// yields up to 8 results; one with none leaves the sequencer idle, and a new
// item is taken only when idle. Output stalls and rate writes hold it. Reset
// (rst_n, asynchronous, active low) sets the input rate to 65536 and clears
// all state at once; a rate write clears the history, block sums and phase.
// ============================================================================
// stereo_audio_rate_converter_top: stereo sample rate converter
// Passthrough, 2x upsampling, block averaging or linear interpolation, chosen
// by the input rate register against the fixed output rate.
// ============================================================================
module stereo_audio_rate_converter_top
    import sarc_pkg::*;
#(
    parameter int OUTPUT_RATE = DEFAULT_OUTPUT_RATE
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [RATE_W-1:0]   cfg_wdata,
    sarc_stream_if.sink         pcm,
    sarc_stream_if.source       resampled
);

    localparam logic [RATE_W-1:0] RATE_PASS = RATE_W'(OUTPUT_RATE);
    localparam logic [RATE_W-1:0] RATE_UP   = RATE_W'(OUTPUT_RATE / 2);
    localparam logic [RATE_W-1:0] RATE_AVG2 = RATE_W'(OUTPUT_RATE * 2);
    localparam logic [RATE_W-1:0] RATE_AVG4 = RATE_W'(OUTPUT_RATE * 4);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE_L,
        S_ISSUE_R,
        S_CAPTURE,
        S_EMIT
    } state_t;

    typedef enum logic [2:0] {
        M_PASS,
        M_UP,
        M_AVG2,
        M_AVG4,
        M_LERP
    } mode_t;

    state_t                  state_reg;
    logic [RATE_W-1:0]       rate_reg;
    sample_t                 prev_l_reg;
    sample_t                 prev_r_reg;
    logic                    prev_valid_reg;
    logic signed [SUM_W-1:0] sum_l_reg;
    logic signed [SUM_W-1:0] sum_r_reg;
    logic [2:0]              sum_count_reg;
    logic [PHASE_W-1:0]      phase_reg;
    sample_t                 cur_l_reg;
    sample_t                 cur_r_reg;
    alu_op_t                 op_reg;
    sample_t                 left_hold_reg;
    logic                    out_valid_reg;
    out_frame_t              out_data_reg;

    mode_t                   mode;
    logic [RATE_W-1:0]       step;
    logic [PHASE_W-1:0]      phase_sum;
    logic signed [SUM_W-1:0] sum_l_new;
    logic signed [SUM_W-1:0] sum_r_new;
    logic [2:0]              count_inc;
    logic                    block_done;
    logic                    accept;
    logic                    emit_go;
    logic                    emit_last;
    logic                    use_left;
    logic                    alu_en;
    alu_req_t                alu_req;
    sample_t                 alu_result;

    always_comb
    begin
        if (rate_reg == '0 || rate_reg == RATE_PASS)
            mode = M_PASS;
        else if (rate_reg == RATE_UP)
            mode = M_UP;
        else if (rate_reg == RATE_AVG2)
            mode = M_AVG2;
        else if (rate_reg == RATE_AVG4)
            mode = M_AVG4;
        else
            mode = M_LERP;
    end

    assign step       = (rate_reg < MIN_STEP) ? MIN_STEP : rate_reg;
    assign phase_sum  = phase_reg + {1'b0, step};
    assign sum_l_new  = sum_l_reg
                        + {{(SUM_W-SAMPLE_W){pcm.data.left_in[SAMPLE_W-1]}}, pcm.data.left_in};
    assign sum_r_new  = sum_r_reg
                        + {{(SUM_W-SAMPLE_W){pcm.data.right_in[SAMPLE_W-1]}}, pcm.data.right_in};
    assign count_inc  = sum_count_reg + 3'd1;
    assign block_done = (mode == M_AVG2) ? (count_inc >= 3'd2) : (count_inc >= 3'd4);

    assign pcm.ready  = (state_reg == S_IDLE) && !cfg_we;
    assign accept     = pcm.valid && pcm.ready;
    assign emit_go    = (state_reg == S_EMIT) && !cfg_we
                        && (!out_valid_reg || resampled.ready);

    always_comb
    begin
        case (mode)
            M_UP:    emit_last = (op_reg != ALU_HALF);
            M_LERP:  emit_last = (phase_sum >= PHASE_ONE);
            default: emit_last = 1'b1;
        endcase
    end

    // The left operands go in first; the right ones follow in the issue-right state.
    assign use_left = (state_reg == S_ISSUE_L);
    assign alu_en   = (state_reg == S_ISSUE_L) || (state_reg == S_ISSUE_R)
                      || (state_reg == S_CAPTURE);

    always_comb
    begin
        alu_req.op   = op_reg;
        alu_req.frac = phase_reg[15:0];
        alu_req.opb  = use_left ? cur_l_reg : cur_r_reg;
        if (op_reg == ALU_AVG2 || op_reg == ALU_AVG4)
            alu_req.opa = use_left ? sum_l_reg : sum_r_reg;
        else if (use_left)
            alu_req.opa = {{(SUM_W-SAMPLE_W){prev_l_reg[SAMPLE_W-1]}}, prev_l_reg};
        else
            alu_req.opa = {{(SUM_W-SAMPLE_W){prev_r_reg[SAMPLE_W-1]}}, prev_r_reg};
    end

    sarc_alu u_alu (
        .clk    (clk),
        .en     (alu_en),
        .req    (alu_req),
        .result (alu_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rate_reg       <= RESET_RATE;
            prev_l_reg     <= '0;
            prev_r_reg     <= '0;
            prev_valid_reg <= 1'b0;
            sum_l_reg      <= '0;
            sum_r_reg      <= '0;
            sum_count_reg  <= '0;
            phase_reg      <= '0;
            cur_l_reg      <= '0;
            cur_r_reg      <= '0;
            op_reg         <= ALU_PASS;
            left_hold_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            if (emit_go)
                out_valid_reg <= 1'b1;
            else if (resampled.ready)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                rate_reg       <= cfg_wdata;
                prev_l_reg     <= '0;
                prev_r_reg     <= '0;
                prev_valid_reg <= 1'b0;
                sum_l_reg      <= '0;
                sum_r_reg      <= '0;
                sum_count_reg  <= '0;
                phase_reg      <= '0;
            end
            else
            begin
                case (state_reg)
                    S_IDLE:
                    begin
                        if (accept)
                        begin
                            cur_l_reg <= pcm.data.left_in;
                            cur_r_reg <= pcm.data.right_in;
                            case (mode)
                                M_PASS:
                                begin
                                    op_reg    <= ALU_PASS;
                                    state_reg <= S_ISSUE_L;
                                end
                                M_UP:
                                begin
                                    // The first frame also stands in as the previous one.
                                    if (!prev_valid_reg)
                                    begin
                                        prev_l_reg     <= pcm.data.left_in;
                                        prev_r_reg     <= pcm.data.right_in;
                                        prev_valid_reg <= 1'b1;
                                    end
                                    op_reg    <= ALU_HALF;
                                    state_reg <= S_ISSUE_L;
                                end
                                M_AVG2,
                                M_AVG4:
                                begin
                                    sum_l_reg     <= sum_l_new;
                                    sum_r_reg     <= sum_r_new;
                                    sum_count_reg <= count_inc;
                                    if (block_done)
                                    begin
                                        op_reg    <= (mode == M_AVG2) ? ALU_AVG2 : ALU_AVG4;
                                        state_reg <= S_ISSUE_L;
                                    end
                                end
                                M_LERP:
                                begin
                                    op_reg <= ALU_LERP;
                                    if (phase_reg < PHASE_ONE)
                                    begin
                                        if (!prev_valid_reg)
                                        begin
                                            prev_l_reg     <= pcm.data.left_in;
                                            prev_r_reg     <= pcm.data.right_in;
                                            prev_valid_reg <= 1'b1;
                                        end
                                        state_reg <= S_ISSUE_L;
                                    end
                                    else
                                    begin
                                        // No output point falls inside this input interval.
                                        phase_reg      <= phase_reg - PHASE_ONE;
                                        prev_l_reg     <= pcm.data.left_in;
                                        prev_r_reg     <= pcm.data.right_in;
                                        prev_valid_reg <= 1'b1;
                                    end
                                end
                                default:
                                begin
                                    state_reg <= S_IDLE;
                                end
                            endcase
                        end
                    end
                    S_ISSUE_L:
                    begin
                        state_reg <= S_ISSUE_R;
                    end
                    S_ISSUE_R:
                    begin
                        state_reg <= S_CAPTURE;
                    end
                    S_CAPTURE:
                    begin
                        left_hold_reg <= alu_result;
                        state_reg     <= S_EMIT;
                    end
                    S_EMIT:
                    begin
                        if (emit_go)
                        begin
                            out_data_reg.left_out    <= left_hold_reg;
                            out_data_reg.right_out   <= alu_result;
                            out_data_reg.last_of_run <= emit_last;
                            case (mode)
                                M_UP:
                                begin
                                    if (emit_last)
                                    begin
                                        prev_l_reg <= cur_l_reg;
                                        prev_r_reg <= cur_r_reg;
                                        state_reg  <= S_IDLE;
                                    end
                                    else
                                    begin
                                        op_reg    <= ALU_PASS;
                                        state_reg <= S_ISSUE_L;
                                    end
                                end
                                M_AVG2,
                                M_AVG4:
                                begin
                                    sum_l_reg     <= '0;
                                    sum_r_reg     <= '0;
                                    sum_count_reg <= '0;
                                    state_reg     <= S_IDLE;
                                end
                                M_LERP:
                                begin
                                    if (emit_last)
                                    begin
                                        phase_reg  <= phase_sum - PHASE_ONE;
                                        prev_l_reg <= cur_l_reg;
                                        prev_r_reg <= cur_r_reg;
                                        state_reg  <= S_IDLE;
                                    end
                                    else
                                    begin
                                        phase_reg <= phase_sum;
                                        state_reg <= S_ISSUE_L;
                                    end
                                end
                                default:
                                begin
                                    state_reg <= S_IDLE;
                                end
                            endcase
                        end
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign resampled.valid = out_valid_reg;
    assign resampled.data  = out_data_reg;

`ifndef SYNTHESIS
    a_partial_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (resampled.valid && !resampled.data.last_of_run) |-> (state_reg != S_IDLE))
        else $error("frame other than the last of its run shown while the sequencer is idle");

    a_lerp_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ISSUE_L && op_reg == ALU_LERP) |-> (phase_reg < PHASE_ONE))
        else $error("interpolation issued with a phase of one or more");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_go && emit_last) |=> (state_reg == S_IDLE))
        else $error("sequencer did not return to idle after the last frame of a run");
`endif

endmodule

@@ hdl/sarc_alu.sv @@
// ============================================================================
// sarc_alu: shared two-stage arithmetic unit of the rate converter
// Stage one forms a product or sum, stage two rounds, shifts and adds the base.
// ============================================================================
module sarc_alu
    import sarc_pkg::*;
(
    input  logic     clk,
    input  logic     en,
    input  alu_req_t req,
    output sample_t  result
);

    logic signed [SUM_W-1:0]   diff;
    logic signed [SUM_W-1:0]   pair_sum;
    logic signed [2*SUM_W-1:0] prod;
    logic signed [2*SUM_W-1:0] pre;

    alu_op_t                   op_s1_reg;
    logic signed [SUM_W-1:0]   base_s1_reg;
    logic signed [2*SUM_W-1:0] pre_s1_reg;
    sample_t                   result_reg;

    logic signed [SUM_W-1:0]   quot;
    logic signed [SUM_W-1:0]   lerp_sum;
    logic signed [SUM_W-1:0]   half_adj;
    logic signed [SUM_W-1:0]   quarter_adj;
    sample_t                   result_next;

    always_comb
    begin
        diff     = {{(SUM_W-SAMPLE_W){req.opb[SAMPLE_W-1]}}, req.opb} - req.opa;
        pair_sum = {{(SUM_W-SAMPLE_W){req.opb[SAMPLE_W-1]}}, req.opb} + req.opa;
        prod     = diff * $signed({2'b00, req.frac});
        case (req.op)
            ALU_LERP: pre = prod;
            ALU_HALF: pre = {{SUM_W{pair_sum[SUM_W-1]}}, pair_sum};
            ALU_AVG2,
            ALU_AVG4: pre = {{SUM_W{req.opa[SUM_W-1]}}, req.opa};
            ALU_PASS: pre = {{(2*SUM_W-SAMPLE_W){req.opb[SAMPLE_W-1]}}, req.opb};
            default:  pre = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_s1_reg   <= req.op;
            base_s1_reg <= req.opa;
            pre_s1_reg  <= pre;
            result_reg  <= result_next;
        end
    end

    // Dropping the low sixteen bits of the product floors the quotient; the
    // halving and block divisions bias negative values to truncate towards zero.
    always_comb
    begin
        quot        = pre_s1_reg[SUM_W+15:16];
        lerp_sum    = base_s1_reg + quot;
        half_adj    = pre_s1_reg[SUM_W-1:0]
                      + {{(SUM_W-1){1'b0}}, pre_s1_reg[SUM_W-1] & pre_s1_reg[0]};
        quarter_adj = pre_s1_reg[SUM_W-1:0]
                      + (pre_s1_reg[SUM_W-1] ? SUM_W'(3) : SUM_W'(0));
        case (op_s1_reg)
            ALU_LERP: result_next = lerp_sum[SAMPLE_W-1:0];
            ALU_HALF,
            ALU_AVG2: result_next = half_adj[SAMPLE_W:1];
            ALU_AVG4: result_next = quarter_adj[SAMPLE_W+1:2];
            ALU_PASS: result_next = pre_s1_reg[SAMPLE_W-1:0];
            default:  result_next = '0;
        endcase
    end

    assign result = result_reg;

endmodule
